// ----- design/fingerprint_ack_packet_parser_unit_defines.svh -----
// Assertion macros used by the acknowledge packet parser.
`ifndef FINGERPRINT_ACK_PACKET_PARSER_UNIT_DEFINES_SVH
`define FINGERPRINT_ACK_PACKET_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FAPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FAPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fapp_pkg.sv -----
package fapp_pkg;

    // Fixed framing bytes of an acknowledge packet.
    localparam logic [7:0] START_HI_BYTE = 8'hEF;
    localparam logic [7:0] START_LO_BYTE = 8'h01;
    localparam logic [7:0] ACK_PID_BYTE  = 8'h07;
    localparam logic [15:0] MIN_LENGTH   = 16'd3;

    // Parser phases, one per header and checksum byte position, and one for all content bytes.
    typedef enum logic [3:0] {
        PH_START0,
        PH_START1,
        PH_ADDR0,
        PH_ADDR1,
        PH_ADDR2,
        PH_ADDR3,
        PH_PID,
        PH_LENHI,
        PH_LENLO,
        PH_BODY,
        PH_CKHI,
        PH_CKLO
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_START    = 3'd1,
        ST_ADDRESS  = 3'd2,
        ST_PID      = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_CHECKSUM = 3'd5
    } status_t;

    // One parser result.
    typedef struct packed {
        status_t     status;
        logic [7:0]  confirm_code;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] body_length;
    } result_t;

endpackage

// ----- design/fapp_core.sv -----
module fapp_core
    import fapp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_en,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] module_address,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ck_high_reg, ck_high_next;
    logic [7:0]  confirm_reg, confirm_next;
    logic [15:0] word_a_reg, word_a_next;
    logic [15:0] word_b_reg, word_b_next;

    logic [15:0] count_inc;
    logic [15:0] length_full;
    logic [7:0]  want_byte;
    logic        finish;

    assign count_inc   = count_reg + 16'd1;
    assign length_full = {length_reg[15:8], rx_byte};

    // Expected address byte, most significant first.
    always_comb begin
        case (phase_reg)
            PH_ADDR0: want_byte = module_address[31:24];
            PH_ADDR1: want_byte = module_address[23:16];
            PH_ADDR2: want_byte = module_address[15:8];
            default:  want_byte = module_address[7:0];
        endcase
    end

    // Next state and result for the byte in hand.
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        sum_next     = sum_reg;
        ck_high_next = ck_high_reg;
        confirm_next = confirm_reg;
        word_a_next  = word_a_reg;
        word_b_next  = word_b_reg;
        finish       = 1'b0;

        res.status       = ST_OK;
        res.confirm_code = confirm_reg;
        res.word_a       = word_a_reg;
        res.word_b       = word_b_reg;
        res.body_length  = length_reg;

        case (phase_reg)
            PH_START0: begin
                if (rx_byte != START_HI_BYTE) begin
                    finish     = 1'b1;
                    res.status = ST_START;
                end else begin
                    phase_next = PH_START1;
                end
            end
            PH_START1: begin
                if (rx_byte != START_LO_BYTE) begin
                    finish     = 1'b1;
                    res.status = ST_START;
                end else begin
                    phase_next = PH_ADDR0;
                end
            end
            PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
                if (rx_byte != want_byte) begin
                    finish     = 1'b1;
                    res.status = ST_ADDRESS;
                end else begin
                    phase_next = phase_t'(phase_reg + 4'd1);
                end
            end
            PH_PID: begin
                if (rx_byte != ACK_PID_BYTE) begin
                    finish     = 1'b1;
                    res.status = ST_PID;
                end else begin
                    sum_next   = {8'd0, rx_byte};
                    phase_next = PH_LENHI;
                end
            end
            PH_LENHI: begin
                length_next = {rx_byte, 8'd0};
                sum_next    = sum_reg + {8'd0, rx_byte};
                phase_next  = PH_LENLO;
            end
            PH_LENLO: begin
                length_next = length_full;
                sum_next    = sum_reg + {8'd0, rx_byte};
                if (length_full < MIN_LENGTH) begin
                    finish          = 1'b1;
                    res.status      = ST_LENGTH;
                    res.body_length = length_full;
                end else begin
                    count_next = 16'd0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                sum_next   = sum_reg + {8'd0, rx_byte};
                count_next = count_inc;
                // Only the first five content bytes are kept.
                case (count_reg)
                    16'd0:   confirm_next = rx_byte;
                    16'd1:   word_a_next  = {rx_byte, 8'd0};
                    16'd2:   word_a_next  = {word_a_reg[15:8], rx_byte};
                    16'd3:   word_b_next  = {rx_byte, 8'd0};
                    16'd4:   word_b_next  = {word_b_reg[15:8], rx_byte};
                    default: ;
                endcase
                if (count_inc >= (length_reg - 16'd2)) begin
                    phase_next = PH_CKHI;
                end
            end
            PH_CKHI: begin
                ck_high_next = rx_byte;
                phase_next   = PH_CKLO;
            end
            PH_CKLO: begin
                finish     = 1'b1;
                res.status = ({ck_high_reg, rx_byte} == sum_reg) ? ST_OK : ST_CHECKSUM;
            end
            default: begin
                phase_next = PH_START0;
                count_next   = 16'd0;
                length_next  = 16'd0;
                sum_next     = 16'd0;
                ck_high_next = 8'd0;
                confirm_next = 8'd0;
                word_a_next  = 16'd0;
                word_b_next  = 16'd0;
            end
        endcase

        // Any result ends the frame and clears its state.
        if (finish) begin
            phase_next   = PH_START0;
            count_next   = 16'd0;
            length_next  = 16'd0;
            sum_next     = 16'd0;
            ck_high_next = 8'd0;
            confirm_next = 8'd0;
            word_a_next  = 16'd0;
            word_b_next  = 16'd0;
        end
    end

    assign res_valid = byte_en && finish;

    // Frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START0;
            count_reg   <= 16'd0;
            length_reg  <= 16'd0;
            sum_reg     <= 16'd0;
            ck_high_reg <= 8'd0;
            confirm_reg <= 8'd0;
            word_a_reg  <= 16'd0;
            word_b_reg  <= 16'd0;
        end else if (byte_en) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            sum_reg     <= sum_next;
            ck_high_reg <= ck_high_next;
            confirm_reg <= confirm_next;
            word_a_reg  <= word_a_next;
            word_b_reg  <= word_b_next;
        end
    end

endmodule

// ----- design/fingerprint_ack_packet_parser_unit.sv -----
// Acknowledge packet checker for a fingerprint module link. Received bytes enter on the
// s_ channel, one request per cycle at full rate unless a waiting result stalls the input; each
// byte is registered, checked against the frame position (start code EF 01, module address,
// identifier 07, length, content, checksum) by one level of logic, and at most one result per
// byte is registered on the m_ channel, after the byte has passed the input register. A result
// comes at the first bad byte or after the last checksum byte, and the next byte starts a new
// frame. While a result waits to be taken, the input register holds one more byte and then the
// input stalls until the result is accepted. The module address is written through cfg_wr_en
// and cfg_wr_data, by the user only while the parser is idle; the block does not enforce it.
`include "fingerprint_ack_packet_parser_unit_defines.svh"

module fingerprint_ack_packet_parser_unit
    import fapp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_confirm_code,
    output logic [15:0] m_word_a,
    output logic [15:0] m_word_b,
    output logic [15:0] m_body_length
);

    logic [31:0] address_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        advance;
    logic        res_valid;
    result_t     res;

    // A byte moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Module address register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg <= 32'hFFFF_FFFF;
        end else if (cfg_wr_en) begin
            address_reg <= cfg_wr_data;
        end
    end

    // Input byte register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    fapp_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_en        (advance),
        .rx_byte        (in_byte_reg),
        .module_address (address_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_confirm_code = out_reg.confirm_code;
    assign m_word_a       = out_reg.word_a;
    assign m_word_b       = out_reg.word_b;
    assign m_body_length  = out_reg.body_length;

    // A stalled input stage only happens behind a stalled result.
    `FAPP_ASSERT_NOW(a_stall_cause, !s_ready, in_valid_reg && out_valid_reg && !m_ready, "input stalled without a stalled result")
    // A good packet always carries room for a confirmation code.
    `FAPP_ASSERT_NOW(a_ok_length, m_valid && (m_status == ST_OK), m_body_length >= MIN_LENGTH, "ok result with short length")
    // A length error reports the short length it saw.
    `FAPP_ASSERT_NOW(a_len_err, m_valid && (m_status == ST_LENGTH), m_body_length < MIN_LENGTH, "length error with valid length")
    // A result is only raised by a byte that moved through the parser.
    `FAPP_ASSERT_NEXT(a_res_source, !advance && !out_valid_reg, !m_valid, "result without a parsed byte")

endmodule

// ----- sim/fingerprint_ack_packet_parser_unit_test.sv -----
`timescale 1ns / 100ps

module fingerprint_ack_packet_parser_unit_test;
    import fapp_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_BYTES   = 360;
    localparam int ADDRESS_PERIOD = 120;
    localparam int QUIET_TAIL     = 100;

    // Content patterns for generated acknowledge packets.
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [7:0]  m_confirm_code;
    logic [15:0] m_word_a;
    logic [15:0] m_word_b;
    logic [15:0] m_body_length;

    // Parser state as the testbench tracks it.
    phase_t      ack_phase = PH_START0;
    logic [31:0] ack_module_address = 32'hFFFF_FFFF;
    logic [15:0] ack_content_count = '0;
    logic [15:0] ack_length = '0;
    logic [15:0] ack_sum = '0;
    logic [7:0]  ack_checksum_high = '0;
    logic [7:0]  ack_confirm = '0;
    logic [15:0] ack_id_word = '0;
    logic [15:0] ack_score_word = '0;

    result_t     expected_acks[$];
    logic [7:0]  frame_bytes[$];
    int          bytes_sent = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b0;

    fingerprint_ack_packet_parser_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_confirm_code (m_confirm_code),
        .m_word_a       (m_word_a),
        .m_word_b       (m_word_b),
        .m_body_length  (m_body_length)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Address byte that the parser expects in one of the four address phases.
    function automatic logic [7:0] address_byte(input phase_t ph);
        int shift;
        shift = 8 * (int'(PH_ADDR3) - int'(ph));
        return 8'(ack_module_address >> shift);
    endfunction

    task automatic clear_frame_state();
        ack_content_count = '0;
        ack_length = '0;
        ack_sum = '0;
        ack_checksum_high = '0;
        ack_confirm = '0;
        ack_id_word = '0;
        ack_score_word = '0;
    endtask

    // A frame ends with one result, and the next byte starts a new frame.
    task automatic close_frame(input status_t code);
        result_t r;
        r.status = code;
        r.confirm_code = ack_confirm;
        r.word_a = ack_id_word;
        r.word_b = ack_score_word;
        r.body_length = ack_length;
        expected_acks.push_back(r);
        ack_phase = PH_START0;
        clear_frame_state();
    endtask

    // Advances the tracked parser by one accepted byte.
    task automatic predict_ack(input logic [7:0] b);
        logic [15:0] received_sum;
        case (ack_phase)
            PH_START0: begin
                clear_frame_state();
                if (b != START_HI_BYTE) close_frame(ST_START);
                else ack_phase = PH_START1;
            end
            PH_START1: begin
                if (b != START_LO_BYTE) close_frame(ST_START);
                else ack_phase = PH_ADDR0;
            end
            PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
                if (b != address_byte(ack_phase)) close_frame(ST_ADDRESS);
                else ack_phase = phase_t'(int'(ack_phase) + 1);
            end
            PH_PID: begin
                if (b != ACK_PID_BYTE) begin
                    close_frame(ST_PID);
                end else begin
                    ack_sum = {8'h00, b};
                    ack_phase = PH_LENHI;
                end
            end
            PH_LENHI: begin
                ack_length = {b, 8'h00};
                ack_sum = ack_sum + {8'h00, b};
                ack_phase = PH_LENLO;
            end
            PH_LENLO: begin
                ack_length = {ack_length[15:8], b};
                ack_sum = ack_sum + {8'h00, b};
                if (ack_length < MIN_LENGTH) begin
                    close_frame(ST_LENGTH);
                end else begin
                    ack_content_count = '0;
                    ack_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                // Only the first five content bytes are kept; all are summed.
                ack_sum = ack_sum + {8'h00, b};
                case (ack_content_count)
                    16'd0: ack_confirm = b;
                    16'd1: ack_id_word = {b, 8'h00};
                    16'd2: ack_id_word = {ack_id_word[15:8], b};
                    16'd3: ack_score_word = {b, 8'h00};
                    16'd4: ack_score_word = {ack_score_word[15:8], b};
                    default: ;
                endcase
                ack_content_count = ack_content_count + 16'd1;
                if (ack_content_count >= ack_length - 16'd2) ack_phase = PH_CKHI;
            end
            PH_CKHI: begin
                ack_checksum_high = b;
                ack_phase = PH_CKLO;
            end
            PH_CKLO: begin
                received_sum = {ack_checksum_high, b};
                close_frame(received_sum == ack_sum ? ST_OK : ST_CHECKSUM);
            end
            default: begin
                ack_phase = PH_START0;
                clear_frame_state();
            end
        endcase
    endtask

    // Sends one byte request, with an occasional gap before it.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_ack(value);
        bytes_sent++;
    endtask

    task automatic send_prefix(input int count);
        int i;
        for (i = 0; i < count; i++) send_byte(frame_bytes[i]);
    endtask

    // Builds a well-formed acknowledge packet in frame_bytes.
    task automatic build_ack(input logic [31:0] addr, input logic [15:0] len,
                             input fill_t fill);
        logic [15:0] sum;
        logic [7:0]  b;
        int          i;
        frame_bytes.delete();
        frame_bytes.push_back(START_HI_BYTE);
        frame_bytes.push_back(START_LO_BYTE);
        frame_bytes.push_back(addr[31:24]);
        frame_bytes.push_back(addr[23:16]);
        frame_bytes.push_back(addr[15:8]);
        frame_bytes.push_back(addr[7:0]);
        frame_bytes.push_back(ACK_PID_BYTE);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        sum = {8'h00, ACK_PID_BYTE} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
        for (i = 0; i < int'(len) - 2; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            frame_bytes.push_back(b);
            sum = sum + {8'h00, b};
        end
        frame_bytes.push_back(sum[15:8]);
        frame_bytes.push_back(sum[7:0]);
    endtask

    task automatic send_ack(input logic [15:0] len, input fill_t fill);
        build_ack(ack_module_address, len, fill);
        send_prefix(frame_bytes.size());
    endtask

    // Drops valid and holds off until every expected result is back.
    task automatic wait_for_acks();
        s_valid <= 1'b0;
        while (expected_acks.size() != 0) @(posedge aclk);
    endtask

    // Feeds bytes that end the current frame as soon as possible.
    task automatic close_open_frame();
        logic [7:0] b;
        while (ack_phase != PH_START0) begin
            b = 8'h00;
            if (ack_phase >= PH_ADDR0 && ack_phase <= PH_ADDR3) b = ~address_byte(ack_phase);
            send_byte(b);
        end
    endtask

    // The address register is only written between frames with the parser drained.
    task automatic set_module_address(input logic [31:0] addr);
        close_open_frame();
        wait_for_acks();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ack_module_address = addr;
    endtask

    // Bytes other than the start code while waiting for a frame.
    task automatic test_stray_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hEE);
        // A start byte followed by a wrong second start byte.
        send_byte(START_HI_BYTE);
        send_byte(8'h00);
        send_byte(START_HI_BYTE);
        send_byte(START_HI_BYTE);
    endtask

    // Faults in each address byte, the identifier and short lengths.
    task automatic test_header_faults();
        int k;
        for (k = 0; k < 4; k++) begin
            build_ack(ack_module_address, 16'd3, FILL_RANDOM);
            frame_bytes[2 + k] = frame_bytes[2 + k] ^ 8'h5A;
            send_prefix(3 + k);
        end
        build_ack(ack_module_address, 16'd3, FILL_RANDOM);
        frame_bytes[6] = 8'h06;
        send_prefix(7);
        build_ack(ack_module_address, 16'd3, FILL_RANDOM);
        frame_bytes[6] = 8'hF8;
        send_prefix(7);
        for (k = 0; k < 3; k++) begin
            build_ack(ack_module_address, 16'd3, FILL_RANDOM);
            frame_bytes[8] = 8'(k);
            send_prefix(9);
        end
    endtask

    // Good packets from the shortest length to long content.
    task automatic test_good_frames();
        send_ack(16'd3, FILL_RANDOM);
        send_ack(16'd4, FILL_RANDOM);
        send_ack(16'd6, FILL_RANDOM);
        send_ack(16'd7, FILL_ONES);
        send_ack(16'd7, FILL_ZERO);
        send_ack(16'd7, FILL_RANDOM);
        send_ack(16'd12, FILL_RANDOM);
    endtask

    // Checksum faults, and a sum large enough to wrap past 16 bits.
    task automatic test_checksum();
        int last;
        build_ack(ack_module_address, 16'd7, FILL_RANDOM);
        last = frame_bytes.size() - 1;
        frame_bytes[last - 1] = frame_bytes[last - 1] ^ 8'h80;
        send_prefix(frame_bytes.size());
        build_ack(ack_module_address, 16'd7, FILL_RANDOM);
        last = frame_bytes.size() - 1;
        frame_bytes[last] = frame_bytes[last] ^ 8'h01;
        send_prefix(frame_bytes.size());
        build_ack(ack_module_address, 16'd10, FILL_RANDOM);
        frame_bytes[14] = frame_bytes[14] ^ 8'h10;
        send_prefix(frame_bytes.size());
        send_ack(16'h0110, FILL_ONES);
    endtask

    // Packets under several register settings, the extremes among them.
    task automatic test_address_values();
        set_module_address(32'h0000_0000);
        send_ack(16'd7, FILL_RANDOM);
        build_ack(32'hFFFF_FFFF, 16'd7, FILL_RANDOM);
        send_prefix(frame_bytes.size());
        set_module_address(32'h8000_0001);
        send_ack(16'd8, FILL_RANDOM);
        set_module_address($urandom);
        send_ack(16'd5, FILL_RANDOM);
        set_module_address(32'hFFFF_FFFF);
        send_ack(16'd7, FILL_RANDOM);
    endtask

    // Mostly well-formed packets with random content, plus faults and noise.
    task automatic test_random_traffic();
        int start_count;
        int done_count;
        int next_address_at;
        int r;
        int pos;
        int len;
        bit paused;
        start_count = bytes_sent;
        next_address_at = ADDRESS_PERIOD;
        paused = 1'b0;
        done_count = 0;
        while (done_count < RANDOM_BYTES) begin
            if (done_count >= next_address_at) begin
                case ($urandom_range(0, 3))
                    0: set_module_address(32'h0000_0000);
                    1: set_module_address(32'hFFFF_FFFF);
                    default: set_module_address($urandom);
                endcase
                next_address_at += ADDRESS_PERIOD;
            end
            // Hold the sender once until the result side has fully drained.
            if (!paused && done_count >= RANDOM_BYTES / 2) begin
                wait_for_acks();
                paused = 1'b1;
            end
            if (done_count >= RANDOM_BYTES - QUIET_TAIL) idle_on = 1'b0;
            else idle_on = ((done_count / 100) % 3) != 2;

            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 80) len = $urandom_range(3, 12);
            else if ($urandom_range(0, 99) < 80) len = $urandom_range(13, 40);
            else len = $urandom_range(41, 300);
            build_ack(ack_module_address, 16'(len), FILL_RANDOM);
            if (r < 70) begin
                send_prefix(frame_bytes.size());
            end else if (r < 80) begin
                pos = $urandom_range(9, frame_bytes.size() - 1);
                frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
                send_prefix(frame_bytes.size());
            end else if (r < 92) begin
                pos = $urandom_range(0, 8);
                if (pos >= 7) begin
                    frame_bytes[7] = 8'h00;
                    frame_bytes[8] = 8'($urandom_range(0, 2));
                    send_prefix(9);
                end else begin
                    frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
                    send_prefix(pos + 1);
                end
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
            done_count = bytes_sent - start_count;
        end
        idle_on = 1'b0;
        close_open_frame();
    endtask

    // Result side stalls in bursts while idling is enabled.
    always begin
        @(posedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    // Compares each result with the oldest expected one.
    always @(posedge aclk) begin : check_ack
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_acks.size() == 0) begin
                report_error($sformatf("result with none expected, status %0d", m_status));
            end else begin
                want = expected_acks.pop_front();
                if (m_status !== want.status)
                    report_error($sformatf("status 0x%0h, expected 0x%0h",
                                           m_status, want.status));
                if (m_confirm_code !== want.confirm_code)
                    report_error($sformatf("confirm_code 0x%0h, expected 0x%0h",
                                           m_confirm_code, want.confirm_code));
                if (m_word_a !== want.word_a)
                    report_error($sformatf("word_a 0x%0h, expected 0x%0h",
                                           m_word_a, want.word_a));
                if (m_word_b !== want.word_b)
                    report_error($sformatf("word_b 0x%0h, expected 0x%0h",
                                           m_word_b, want.word_b));
                if (m_body_length !== want.body_length)
                    report_error($sformatf("body_length 0x%0h, expected 0x%0h",
                                           m_body_length, want.body_length));
            end
        end
    end

    // Ends the run when no request moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        test_stray_bytes();
        test_header_faults();
        test_good_frames();
        test_checksum();
        test_address_values();
        test_random_traffic();

        wait_for_acks();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_acks.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
